// ===== rtl/core/hrrn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrrn_pkg
// shared types and widths of the response-ratio scheduler
// ----------------------------------------------------------------------------
package hrrn_pkg;

  localparam int unsigned ARR_W  = 16;
  localparam int unsigned SVC_W  = 16;
  localparam int unsigned TIME_W = 21;
  localparam int unsigned SUM_W  = 25;
  localparam int unsigned PIDX_W = 4;
  // (time - arrival) + service fits one bit above the time width
  localparam int unsigned NUM_W  = TIME_W + 1;
  localparam int unsigned PROD_W = NUM_W + SVC_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [ARR_W-1:0] arr_at;
    logic [SVC_W-1:0] run_len;
    logic             last_process;
  } hrrn_item_t;

  // head of the ingest queue as seen by the engine
  typedef struct packed {
    logic       valid;
    hrrn_item_t item;
  } hrrn_qhead_t;

  typedef struct packed {
    logic [PIDX_W-1:0] process_index;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [SUM_W-1:0]  total_waiting;
    logic [SUM_W-1:0]  total_turnaround;
    logic              last_result;
  } hrrn_result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS1,
    S_PASS2,
    S_EMIT
  } sched_state_e;

  typedef enum logic [1:0] {
    PH_READ,
    PH_EVAL,
    PH_MUL,
    PH_CMP
  } scan_phase_e;

endpackage

// ===== rtl/core/hrrn_ingest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrrn_ingest
// front end: takes process items, fixes zero service, queues them
// ----------------------------------------------------------------------------
module hrrn_ingest (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hrrn_pkg::hrrn_item_t  in_item_i,
  output hrrn_pkg::hrrn_qhead_t head_o,
  input  logic                pop_i
);
  import hrrn_pkg::*;

  hrrn_item_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]       q_cnt_q, q_cnt_d;
  logic                    push;
  hrrn_item_t              item_fixed;

  // zero service time runs as one
  always_comb begin
    item_fixed = in_item_i;
    if (in_item_i.run_len == '0) begin
      item_fixed.run_len = SVC_W'(1);
    end
  end

  assign in_ready_o  = (q_cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_valid_i && in_ready_o;
  assign head_o.valid = (q_cnt_q != '0);
  assign head_o.item  = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    q_cnt_d  = q_cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop_i) begin
      q_cnt_d = q_cnt_q + QCNT_W'(1);
    end else if (!push && pop_i) begin
      q_cnt_d = q_cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      q_cnt_q  <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item_fixed;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("ingest queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (q_cnt_q != '0))
    else $error("pop from empty ingest queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop_i) |=> (q_cnt_q == $past(q_cnt_q) + QCNT_W'(1)))
    else $error("ingest queue count did not follow a lone push");
`endif

endmodule

// ===== rtl/core/hrrn_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrrn_engine
// back end: process store, two-pass selection per dispatch, result register
// ----------------------------------------------------------------------------
module hrrn_engine #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hrrn_pkg::hrrn_qhead_t   head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hrrn_pkg::hrrn_result_t  out_res_o
);
  import hrrn_pkg::*;

  localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);

  // process store, one write and one registered read port
  logic [ARR_W-1:0] arr_mem [MAX_PROCS];
  logic [SVC_W-1:0] svc_mem [MAX_PROCS];
  logic [ARR_W-1:0] rd_arr_q;
  logic [SVC_W-1:0] rd_svc_q;
  logic             mem_we;

  sched_state_e      state_q, state_d;
  scan_phase_e       phase_q, phase_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [MAX_PROCS-1:0] fin_q, fin_d;
  logic [TIME_W-1:0] cur_q, cur_d;
  logic [SUM_W-1:0]  wsum_q, wsum_d;
  logic [SUM_W-1:0]  tsum_q, tsum_d;
  logic              any_rdy_q, any_rdy_d;
  logic              have_min_q, have_min_d;
  logic              have_best_q, have_best_d;
  logic              out_valid_q, out_valid_d;

  logic [ARR_W-1:0]  min_arr_q, min_arr_d;
  logic [IDX_W-1:0]  best_q, best_d;
  logic [NUM_W-1:0]  num_b_q, num_b_d;
  logic [SVC_W-1:0]  svc_b_q, svc_b_d;
  logic [ARR_W-1:0]  arr_b_q, arr_b_d;
  logic [NUM_W-1:0]  num_i_q, num_i_d;
  logic [SVC_W-1:0]  svc_i_q, svc_i_d;
  logic [ARR_W-1:0]  arr_i_q, arr_i_d;
  logic [PROD_W-1:0] prod_l_q, prod_l_d;
  logic [PROD_W-1:0] prod_r_q, prod_r_d;
  hrrn_result_t      res_q, res_d;

  logic              fin_bit;
  logic              ready_now;
  logic [NUM_W-1:0]  num_now;
  logic              last_elem;
  logic              last_disp;
  logic              out_free;
  logic              any_n, have_n, min_upd;
  logic [ARR_W-1:0]  min_n;
  logic [TIME_W-1:0] finish_t, tat_t, wait_t;
  logic [SUM_W-1:0]  wsum_n, tsum_n;

  assign fin_bit   = fin_q[idx_q];
  assign ready_now = !fin_bit && (TIME_W'(rd_arr_q) <= cur_q);
  assign num_now   = NUM_W'(cur_q) - NUM_W'(rd_arr_q) + NUM_W'(rd_svc_q);
  assign last_elem = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;
  assign last_disp = (k_q + CNT_W'(1)) == cnt_q;
  assign out_free  = !out_valid_q || out_ready_i;

  assign any_n   = any_rdy_q || ready_now;
  assign have_n  = have_min_q || !fin_bit;
  assign min_upd = !fin_bit && (!have_min_q || (rd_arr_q < min_arr_q));
  assign min_n   = min_upd ? rd_arr_q : min_arr_q;

  assign finish_t = cur_q + TIME_W'(svc_b_q);
  assign tat_t    = finish_t - TIME_W'(arr_b_q);
  assign wait_t   = tat_t - TIME_W'(svc_b_q);
  assign wsum_n   = wsum_q + SUM_W'(wait_t);
  assign tsum_n   = tsum_q + SUM_W'(tat_t);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    fin_d       = fin_q;
    cur_d       = cur_q;
    wsum_d      = wsum_q;
    tsum_d      = tsum_q;
    any_rdy_d   = any_rdy_q;
    have_min_d  = have_min_q;
    have_best_d = have_best_q;
    out_valid_d = out_valid_q && !out_ready_i;
    min_arr_d   = min_arr_q;
    best_d      = best_q;
    num_b_d     = num_b_q;
    svc_b_d     = svc_b_q;
    arr_b_d     = arr_b_q;
    num_i_d     = num_i_q;
    svc_i_d     = svc_i_q;
    arr_i_d     = arr_i_q;
    prod_l_d    = prod_l_q;
    prod_r_d    = prod_r_q;
    res_d       = res_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          // a full store drops the item but still honours its last flag
          if (cnt_q < CNT_W'(MAX_PROCS)) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CNT_W'(1);
          end
          if (head_i.item.last_process) begin
            state_d    = S_PASS1;
            phase_d    = PH_READ;
            idx_d      = '0;
            k_d        = '0;
            any_rdy_d  = 1'b0;
            have_min_d = 1'b0;
          end
        end
      end

      // readiness and earliest unfinished arrival
      S_PASS1: begin
        case (phase_q)
          PH_READ: begin
            phase_d = PH_EVAL;
          end
          PH_EVAL: begin
            any_rdy_d  = any_n;
            have_min_d = have_n;
            min_arr_d  = min_n;
            phase_d    = PH_READ;
            if (last_elem) begin
              state_d     = S_PASS2;
              idx_d       = '0;
              have_best_d = 1'b0;
              // nothing ready: jump to the earliest arrival
              if (!any_n && have_n) begin
                cur_d = TIME_W'(min_n);
              end
            end else begin
              idx_d = idx_q + IDX_W'(1);
            end
          end
          default: begin
            phase_d = PH_READ;
          end
        endcase
      end

      // best response ratio by cross-multiplication, ties keep the lower index
      S_PASS2: begin
        case (phase_q)
          PH_READ: begin
            phase_d = PH_EVAL;
          end
          PH_EVAL: begin
            if (ready_now && have_best_q) begin
              num_i_d = num_now;
              svc_i_d = rd_svc_q;
              arr_i_d = rd_arr_q;
              phase_d = PH_MUL;
            end else begin
              if (ready_now) begin
                best_d      = idx_q;
                num_b_d     = num_now;
                svc_b_d     = rd_svc_q;
                arr_b_d     = rd_arr_q;
                have_best_d = 1'b1;
              end
              phase_d = PH_READ;
              if (last_elem) begin
                state_d = S_EMIT;
              end else begin
                idx_d = idx_q + IDX_W'(1);
              end
            end
          end
          PH_MUL: begin
            prod_l_d = PROD_W'(num_i_q) * PROD_W'(svc_b_q);
            prod_r_d = PROD_W'(num_b_q) * PROD_W'(svc_i_q);
            phase_d  = PH_CMP;
          end
          PH_CMP: begin
            if (prod_l_q > prod_r_q) begin
              best_d  = idx_q;
              num_b_d = num_i_q;
              svc_b_d = svc_i_q;
              arr_b_d = arr_i_q;
            end
            phase_d = PH_READ;
            if (last_elem) begin
              state_d = S_EMIT;
            end else begin
              idx_d = idx_q + IDX_W'(1);
            end
          end
          default: begin
            phase_d = PH_READ;
          end
        endcase
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          res_d.process_index        = PIDX_W'(best_q);
          res_d.start_time           = cur_q;
          res_d.finish_time          = finish_t;
          res_d.turnaround           = tat_t;
          res_d.waiting              = wait_t;
          res_d.total_waiting        = wsum_n;
          res_d.total_turnaround     = tsum_n;
          res_d.last_result          = last_disp;
          if (last_disp) begin
            state_d = S_IDLE;
            cnt_d   = '0;
            k_d     = '0;
            fin_d   = '0;
            cur_d   = '0;
            wsum_d  = '0;
            tsum_d  = '0;
          end else begin
            state_d       = S_PASS1;
            phase_d       = PH_READ;
            idx_d         = '0;
            k_d           = k_q + CNT_W'(1);
            fin_d[best_q] = 1'b1;
            cur_d         = finish_t;
            wsum_d        = wsum_n;
            tsum_d        = tsum_n;
            any_rdy_d     = 1'b0;
            have_min_d    = 1'b0;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_READ;
      idx_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      fin_q       <= '0;
      cur_q       <= '0;
      wsum_q      <= '0;
      tsum_q      <= '0;
      any_rdy_q   <= 1'b0;
      have_min_q  <= 1'b0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      fin_q       <= fin_d;
      cur_q       <= cur_d;
      wsum_q      <= wsum_d;
      tsum_q      <= tsum_d;
      any_rdy_q   <= any_rdy_d;
      have_min_q  <= have_min_d;
      have_best_q <= have_best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_arr_q <= min_arr_d;
    best_q    <= best_d;
    num_b_q   <= num_b_d;
    svc_b_q   <= svc_b_d;
    arr_b_q   <= arr_b_d;
    num_i_q   <= num_i_d;
    svc_i_q   <= svc_i_d;
    arr_i_q   <= arr_i_d;
    prod_l_q  <= prod_l_d;
    prod_r_q  <= prod_r_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      arr_mem[cnt_q[IDX_W-1:0]] <= head_i.item.arr_at;
      svc_mem[cnt_q[IDX_W-1:0]] <= head_i.item.run_len;
    end
    rd_arr_q <= arr_mem[idx_q];
    rd_svc_q <= svc_mem[idx_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_PROCS))
    else $error("process count beyond store depth");

  a_emit_has_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> have_best_q)
    else $error("dispatch without a selected process");

  a_emit_unfinished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |-> !fin_q[best_q])
    else $error("dispatched process already finished");

  a_set_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free && last_disp) |=>
      (state_q == S_IDLE && cnt_q == '0 && fin_q == '0 && cur_q == '0))
    else $error("state not cleared after final dispatch");
`endif

endmodule

// ===== rtl/core/hrrn_scheduler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrrn_scheduler_unit
// non-preemptive highest-response-ratio-next scheduler over a loaded set
// ----------------------------------------------------------------------------
// Load items are taken one per cycle into a two-entry queue and written to the
// process store at one per cycle; an item with tlast set closes the set and
// starts a schedule, during which the queue fills and then stalls the slave
// side. Each dispatch walks the store twice through its single registered
// read port: a first pass (a read and an evaluate step per stored process)
// finds whether any unfinished process has arrived and the earliest
// unfinished arrival, a second pass (the same steps, plus a multiply and a
// compare step for each ready process after the first, owing to the
// cross-multiply compare) picks the best ratio, then the emit state writes
// the result register once the master side can take it. Only unfinished
// processes can be ready. Results leave through a registered master port; a
// store-full item is dropped but its tlast is honoured.
module hrrn_scheduler_unit #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave side: one process per transfer
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // arrival[15:0], service[31:16]
  input  logic         s_axis_tlast,   // last_process
  // master side: one dispatch per transfer
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // process_index[3:0], start_time[24:4],
                                       // finish_time[45:25], turnaround[66:46],
                                       // waiting[87:67], total_waiting[112:88],
                                       // total_turnaround[137:113], zero pad
  output logic         m_axis_tlast    // last_result
);
  import hrrn_pkg::*;

  hrrn_item_t   in_item;
  hrrn_qhead_t  head;
  logic         pop;
  hrrn_result_t res;

  // unpack the slave transfer
  assign in_item.arr_at       = s_axis_tdata[15:0];
  assign in_item.run_len      = s_axis_tdata[31:16];
  assign in_item.last_process = s_axis_tlast;

  // front end: zero-service fix and queue
  hrrn_ingest u_ingest (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .head_o     (head),
    .pop_i      (pop)
  );

  // back end: store, selection passes and result register
  hrrn_engine #(
    .MAX_PROCS (MAX_PROCS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // pack the master transfer, process index in the lowest bits
  assign m_axis_tdata = {6'b0,
                         res.total_turnaround,
                         res.total_waiting,
                         res.waiting,
                         res.turnaround,
                         res.finish_time,
                         res.start_time,
                         res.process_index};
  assign m_axis_tlast = res.last_result;

endmodule
